// ----- src/tfd_pkg.sv -----
// Shared types, constants and angle helpers for the tilt and fall detector.
// Used by every module of the block; depends on nothing else.
package tfd_pkg;

	localparam int RAW_W       = 13;
	localparam int ANGLE_W     = 12;
	localparam int TICK_W      = 32;
	localparam int THR_W       = 11;
	localparam int SETTLE_W    = 20;
	localparam int LEVEL_W     = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 72;
	localparam int DIV_SHIFT   = 32;
	localparam int HALF_TURN   = 1800;

	// Fixed limits of the forward fall rule, tenths of a degree
	localparam logic signed [ANGLE_W-1:0] FWD_ROLL_MIN  = 12'sd100;
	localparam logic signed [ANGLE_W-1:0] FWD_PITCH_MAX = -12'sd60;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETTLE_TICKS   = 3'd0,
		CFG_SIDE_ROLL_MIN  = 3'd1,
		CFG_SIDE_PITCH_MAX = 3'd2,
		CFG_DELTA_ROLL_MIN = 3'd3,
		CFG_DELTA_PITCH_MAX = 3'd4,
		CFG_COMB_ROLL_MIN  = 3'd5,
		CFG_COMB_PITCH_MIN = 3'd6,
		CFG_FWD_PITCH_MAX  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [SETTLE_W-1:0]       settle_ticks;
		logic [THR_W-1:0]          side_roll_min;
		logic [THR_W-1:0]          side_flat_pitch_max;
		logic [THR_W-1:0]          delta_roll_min;
		logic [THR_W-1:0]          delta_flat_pitch_max;
		logic [THR_W-1:0]          combined_roll_min;
		logic [THR_W-1:0]          combined_pitch_min;
		logic signed [ANGLE_W-1:0] forward_pitch_max;
	} tfd_cfg_t;

	localparam tfd_cfg_t CFG_RESET = '{
		settle_ticks:         20'd2000,
		side_roll_min:        11'd1050,
		side_flat_pitch_max:  11'd350,
		delta_roll_min:       11'd900,
		delta_flat_pitch_max: 11'd450,
		combined_roll_min:    11'd550,
		combined_pitch_min:   11'd350,
		forward_pitch_max:    12'sd700
	};

	// Fold a value in -4096..4095 into -1799..1800; one turn either way suffices.
	function automatic logic signed [ANGLE_W-1:0] wrap_angle(input logic signed [RAW_W-1:0] a);
		logic signed [RAW_W-1:0] t;
		if (a > 13'sd1800) begin
			t = a - 13'sd3600;
		end else if (a < -13'sd1799) begin
			t = a + 13'sd3600;
		end else begin
			t = a;
		end
		return ANGLE_W'(t);
	endfunction

	function automatic logic [ANGLE_W-1:0] angle_mag(input logic signed [ANGLE_W-1:0] a);
		return a[ANGLE_W-1] ? ANGLE_W'(-a) : ANGLE_W'(a);
	endfunction

endpackage

// ----- src/tfd_mean_div.sv -----
// Baseline mean: signed accumulator divided by the sample count, truncated toward zero.
// Reciprocal multiply in one stage, remainder correction in the next. Uses tfd_pkg.
module tfd_mean_div #(
	parameter int BASELINE_SAMPLES = 20,
	parameter int ACC_W            = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ACC_W-1:0]           sum,
	output logic                              done,
	output logic signed [tfd_pkg::ANGLE_W-1:0] mean
);
	import tfd_pkg::*;

	localparam int MAG_W  = ACC_W - 1;
	localparam int PROD_W = MAG_W + DIV_SHIFT;
	localparam logic [DIV_SHIFT-1:0] RECIP =
		DIV_SHIFT'((65'd1 << DIV_SHIFT) / BASELINE_SAMPLES);
	localparam logic [MAG_W-1:0] DIVISOR = MAG_W'(BASELINE_SAMPLES);

	logic [MAG_W-1:0]  sum_mag;
	logic              valid_s1;
	logic              neg_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [MAG_W-1:0]  q_est;
	logic [MAG_W-1:0]  rem;
	logic [MAG_W-1:0]  q_fix;

	assign sum_mag = sum[ACC_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_s1  <= sum[ACC_W-1];
			mag_s1  <= sum_mag;
			prod_s1 <= PROD_W'(sum_mag) * PROD_W'(RECIP);
		end
	end

	// Estimate is the true quotient or one below it
	always_comb begin
		q_est = prod_s1[PROD_W-1:DIV_SHIFT];
		rem   = mag_s1 - MAG_W'(q_est * DIVISOR);
		q_fix = (rem >= DIVISOR) ? q_est + 1'b1 : q_est;
	end

	assign done = valid_s1;
	assign mean = neg_s1 ? ANGLE_W'(-q_fix) : ANGLE_W'(q_fix);

endmodule

// ----- src/tfd_rules.sv -----
// Posture rule evaluation: side, roll change, combined and forward rules.
// Pure compare logic on wrapped angles and baseline changes. Uses tfd_pkg.
module tfd_rules (
	input  logic signed [tfd_pkg::ANGLE_W-1:0] roll,
	input  logic signed [tfd_pkg::ANGLE_W-1:0] pitch,
	input  logic signed [tfd_pkg::ANGLE_W-1:0] roll_change,
	input  logic signed [tfd_pkg::ANGLE_W-1:0] pitch_change,
	input  tfd_pkg::tfd_cfg_t                  cfg,
	output logic                               hit
);
	import tfd_pkg::*;

	logic [ANGLE_W-1:0] roll_mag;
	logic [ANGLE_W-1:0] pitch_mag;
	logic [ANGLE_W-1:0] dr_mag;
	logic [ANGLE_W-1:0] dp_mag;
	logic side_rule;
	logic change_rule;
	logic comb_rule;
	logic fwd_rule;

	always_comb begin
		roll_mag  = angle_mag(roll);
		pitch_mag = angle_mag(pitch);
		dr_mag    = angle_mag(roll_change);
		dp_mag    = angle_mag(pitch_change);

		side_rule   = (roll_mag >= ANGLE_W'(cfg.side_roll_min)) &&
		              (pitch_mag <= ANGLE_W'(cfg.side_flat_pitch_max));
		change_rule = (dr_mag >= ANGLE_W'(cfg.delta_roll_min)) &&
		              (pitch_mag <= ANGLE_W'(cfg.delta_flat_pitch_max));
		comb_rule   = (dr_mag >= ANGLE_W'(cfg.combined_roll_min)) &&
		              (dp_mag >= ANGLE_W'(cfg.combined_pitch_min)) &&
		              (pitch_mag <= ANGLE_W'(cfg.delta_flat_pitch_max));
		fwd_rule    = (roll_change >= FWD_ROLL_MIN) && (pitch_change <= FWD_PITCH_MAX) &&
		              (pitch <= cfg.forward_pitch_max);

		hit = side_rule || change_rule || comb_rule || fwd_rule;
	end

endmodule

// ----- src/tilt_fall_detector.sv -----
// Tilt and fall detector, top level: stream ports, config registers, calibration and confirm.
// Depends on tfd_pkg, tfd_mean_div and tfd_rules.

// One orientation sample (roll, pitch, yaw in tenths of a degree plus a tick count) enters
// per transaction and one result leaves per sample, in order. Angles are folded into
// -179.9..180.0 degrees. The first BASELINE_SAMPLES samples build roll and pitch totals; the
// sample that completes them sets is_calibrated, and the baselines become the totals' means,
// truncated toward zero. For settle_ticks ticks after that sample, rules are held off and
// the confirm counter stays cleared. Then each sample tests four posture rules; the confirm
// counter counts consecutive hits up to CONFIRM_SAMPLES and the alarm bit is high while it
// is full. Throughput is one sample per clock while results are taken, with a single
// bubble after the calibrating sample while the mean divider's correction stage settles
// the baselines. A result passes through two registers: one input register that folds the
// angles, one result register behind the rule and counter logic. The result register frees
// the input side, so a new sample is taken while a result still waits.
// Configuration writes take effect at the next edge and are meant for idle periods only.
module tilt_fall_detector #(
	parameter int BASELINE_SAMPLES = 20,
	parameter int CONFIRM_SAMPLES  = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [tfd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tfd_pkg::CFG_DATA_W-1:0]       cfg_data,
	// sample input
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// roll_in[12:0], pitch_in[25:13], yaw_in[38:26], now_ticks[70:39], zero[71]
	input  logic [tfd_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// result output
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// roll_out[11:0], pitch_out[23:12], yaw_out[35:24], roll_change[47:36],
	// pitch_change[59:48], is_calibrated[60], posture_hit[61], confirm_level[63:62],
	// alarm[64], zero[71:65]
	output logic [tfd_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
	import tfd_pkg::*;

	localparam int ACC_W = $clog2(BASELINE_SAMPLES * HALF_TURN + 1) + 1;
	localparam int CNT_W = $clog2(BASELINE_SAMPLES + 1);
	localparam logic [CNT_W-1:0]   CAL_COUNT   = CNT_W'(BASELINE_SAMPLES);
	localparam logic [LEVEL_W-1:0] CONFIRM_MAX = LEVEL_W'(CONFIRM_SAMPLES);

	// configuration
	tfd_cfg_t cfg_q;

	// input register
	logic                      s1_valid_q;
	logic signed [ANGLE_W-1:0] roll_s1;
	logic signed [ANGLE_W-1:0] pitch_s1;
	logic signed [ANGLE_W-1:0] yaw_s1;
	logic [TICK_W-1:0]         ticks_s1;

	// detector state
	logic signed [ACC_W-1:0]   roll_acc_q;
	logic signed [ACC_W-1:0]   pitch_acc_q;
	logic signed [ANGLE_W-1:0] roll_base_q;
	logic signed [ANGLE_W-1:0] pitch_base_q;
	logic [CNT_W-1:0]          count_q;
	logic                      cal_q;
	logic [LEVEL_W-1:0]        confirm_q;
	logic [TICK_W-1:0]         cal_time_q;

	// result register
	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] roll_q;
	logic signed [ANGLE_W-1:0] pitch_q;
	logic signed [ANGLE_W-1:0] yaw_q;
	logic signed [ANGLE_W-1:0] dr_q;
	logic signed [ANGLE_W-1:0] dp_q;
	logic                      cal_out_q;
	logic                      hit_q;
	logic [LEVEL_W-1:0]        level_q;
	logic                      alarm_q;

	// stage logic
	logic                      advance;
	logic                      div_start;
	logic                      roll_div_done;
	logic                      pitch_div_done;
	logic signed [ANGLE_W-1:0] roll_mean;
	logic signed [ANGLE_W-1:0] pitch_mean;
	logic signed [ACC_W-1:0]   roll_total;
	logic signed [ACC_W-1:0]   pitch_total;
	logic [CNT_W-1:0]          count_nxt;
	logic                      cal_done;
	logic signed [ANGLE_W-1:0] dr_raw;
	logic signed [ANGLE_W-1:0] dp_raw;
	logic [TICK_W-1:0]         elapsed;
	logic                      settling;
	logic                      rule_hit;
	logic                      detect;
	logic [LEVEL_W-1:0]        confirm_nxt;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SETTLE_TICKS:    cfg_q.settle_ticks         <= cfg_data;
				CFG_SIDE_ROLL_MIN:   cfg_q.side_roll_min        <= cfg_data[THR_W-1:0];
				CFG_SIDE_PITCH_MAX:  cfg_q.side_flat_pitch_max  <= cfg_data[THR_W-1:0];
				CFG_DELTA_ROLL_MIN:  cfg_q.delta_roll_min       <= cfg_data[THR_W-1:0];
				CFG_DELTA_PITCH_MAX: cfg_q.delta_flat_pitch_max <= cfg_data[THR_W-1:0];
				CFG_COMB_ROLL_MIN:   cfg_q.combined_roll_min    <= cfg_data[THR_W-1:0];
				CFG_COMB_PITCH_MIN:  cfg_q.combined_pitch_min   <= cfg_data[THR_W-1:0];
				CFG_FWD_PITCH_MAX:   cfg_q.forward_pitch_max    <= cfg_data[ANGLE_W-1:0];
			endcase
		end
	end

	// ---------------- handshake ----------------
	// Hold the input register while the result register is full and not being taken,
	// or while the baseline divider is still finishing.
	assign advance       = s1_valid_q && !roll_div_done && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign m_axis_tvalid = out_valid_q;

	// ---------------- input register: fold angles on the way in ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			roll_s1  <= wrap_angle(s_axis_tdata[12:0]);
			pitch_s1 <= wrap_angle(s_axis_tdata[25:13]);
			yaw_s1   <= wrap_angle(s_axis_tdata[38:26]);
			ticks_s1 <= s_axis_tdata[70:39];
		end
	end

	// ---------------- calibration and detection ----------------
	always_comb begin
		roll_total  = roll_acc_q + ACC_W'(roll_s1);
		pitch_total = pitch_acc_q + ACC_W'(pitch_s1);
		count_nxt   = count_q + 1'b1;
		cal_done    = count_nxt >= CAL_COUNT;
		div_start   = advance && !cal_q && cal_done;

		dr_raw   = wrap_angle(RAW_W'(roll_s1) - RAW_W'(roll_base_q));
		dp_raw   = wrap_angle(RAW_W'(pitch_s1) - RAW_W'(pitch_base_q));
		elapsed  = ticks_s1 - cal_time_q;
		settling = elapsed < TICK_W'(cfg_q.settle_ticks);
		detect   = cal_q && !settling;

		// advance the run of hits, saturate when full, drop it on a miss
		if (!rule_hit) begin
			confirm_nxt = '0;
		end else if (confirm_q < CONFIRM_MAX) begin
			confirm_nxt = confirm_q + 1'b1;
		end else begin
			confirm_nxt = confirm_q;
		end
	end

	tfd_rules u_rules (
		.roll         (roll_s1),
		.pitch        (pitch_s1),
		.roll_change  (dr_raw),
		.pitch_change (dp_raw),
		.cfg          (cfg_q),
		.hit          (rule_hit)
	);

	tfd_mean_div #(
		.BASELINE_SAMPLES (BASELINE_SAMPLES),
		.ACC_W            (ACC_W)
	) u_roll_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (roll_total),
		.done   (roll_div_done),
		.mean   (roll_mean)
	);

	tfd_mean_div #(
		.BASELINE_SAMPLES (BASELINE_SAMPLES),
		.ACC_W            (ACC_W)
	) u_pitch_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (pitch_total),
		.done   (pitch_div_done),
		.mean   (pitch_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_acc_q   <= '0;
			pitch_acc_q  <= '0;
			roll_base_q  <= '0;
			pitch_base_q <= '0;
			count_q      <= '0;
			cal_q        <= 1'b0;
			confirm_q    <= '0;
			cal_time_q   <= '0;
		end else begin
			// both dividers start together, so one done covers both baselines
			if (roll_div_done && pitch_div_done) begin
				roll_base_q  <= roll_mean;
				pitch_base_q <= pitch_mean;
			end
			if (advance) begin
				if (!cal_q) begin
					roll_acc_q  <= roll_total;
					pitch_acc_q <= pitch_total;
					count_q     <= count_nxt;
					if (cal_done) begin
						cal_q      <= 1'b1;
						cal_time_q <= ticks_s1;
					end
				end else if (settling) begin
					confirm_q <= '0;
				end else begin
					confirm_q <= confirm_nxt;
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			roll_q    <= roll_s1;
			pitch_q   <= pitch_s1;
			yaw_q     <= yaw_s1;
			// changes read as zero until the baselines exist
			dr_q      <= cal_q ? dr_raw : '0;
			dp_q      <= cal_q ? dp_raw : '0;
			cal_out_q <= cal_q || cal_done;
			hit_q     <= detect && rule_hit;
			level_q   <= detect ? confirm_nxt : '0;
			alarm_q   <= detect && (confirm_nxt >= CONFIRM_MAX);
		end
	end

	assign m_axis_tdata = {7'd0, alarm_q, level_q, hit_q, cal_out_q,
	                       dp_q, dr_q, yaw_q, pitch_q, roll_q};

endmodule

// ----- src/tfd_checker.sv -----
// Port-level assertions for the tilt and fall detector, bound to the top level.
// Depends on tfd_pkg for the data widths.
module tfd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tfd_pkg::*;

	logic               cal;
	logic               hit;
	logic [LEVEL_W-1:0] level;
	logic               alarm;

	assign cal   = m_axis_tdata[60];
	assign hit   = m_axis_tdata[61];
	assign level = m_axis_tdata[63:62];
	assign alarm = m_axis_tdata[64];

	// a stalled result transaction holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// before calibration nothing is detected and no change is reported
	a_uncal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !cal |-> m_axis_tdata[59:36] == 24'd0 && !hit && level == '0 && !alarm)
		else $error("detection output before calibration");

	// a nonzero confirm level only follows a rule hit
	a_level_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && level != '0 |-> hit && cal)
		else $error("confirm level without a hit");

	// the alarm only rises on a hit with a nonzero level
	a_alarm_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && alarm |-> hit && level != '0)
		else $error("alarm without a confirmed hit");

endmodule

bind tilt_fall_detector tfd_checker u_tfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
